/* hw/rtl/rema_pkg.sv */
// Package for the Roberts edge magnitude and angle block.
// Holds the shared constants, the command and status structs and the
// arctangent threshold tables. Depends on nothing.
package rema_pkg;

	localparam int MAX_ROW_WIDTH_DEF = 512;
	localparam int CFG_W             = 10;
	localparam int PIX_W             = 8;
	localparam int MAG_W             = 8;
	localparam int ANG_W             = 7;
	localparam int COL_W             = 9;
	localparam int LEN_W             = 17;
	localparam int SQRT_BITS         = 10;
	localparam int NTHRESH           = 45;
	localparam int K_W               = 6;
	localparam int TRIG_W            = 31;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 10'd512;
	localparam logic [ANG_W-1:0] ANGLE_RIGHT     = 7'd90;

	typedef struct packed {
		logic capture;
		logic load;
		logic start;
		logic job;
		logic step;
		logic finish;
		logic last;
	} cmd_t;

	typedef struct packed {
		logic has0;
		logic has1;
		logic iter_done;
	} sts_t;

	typedef logic [TRIG_W-1:0] trig_tab_t [NTHRESH];

	function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	// cos and sin of (k + 0.5) degrees in Q30, built by repeated rotation.
	function automatic trig_tab_t build_tab(bit want_sin);
		trig_tab_t   tab;
		logic [63:0] h, h2, h3, h4, s, c, s1, c1, pc, ps, nc, ns;
		h  = (64'h3243F6A8885A308D / 64'd360 + 64'd536870912) >> 30;
		h2 = qmul(h, h);
		h3 = qmul(h2, h);
		h4 = qmul(h2, h2);
		s  = h - (h3 + 64'd3) / 64'd6;
		c  = 64'd1073741824 - (h2 + 64'd1) / 64'd2 + (h4 + 64'd12) / 64'd24;
		s1 = 64'd2 * qmul(s, c);
		c1 = 64'd1073741824 - 64'd2 * qmul(s, s);
		pc = c;
		ps = s;
		for (int k = 0; k < NTHRESH; k++) begin
			tab[k] = want_sin ? ps[TRIG_W-1:0] : pc[TRIG_W-1:0];
			nc = qmul(pc, c1) - qmul(ps, s1);
			ns = qmul(ps, c1) + qmul(pc, s1);
			pc = nc;
			ps = ns;
		end
		return tab;
	endfunction

	localparam trig_tab_t COS_Q30 = build_tab(1'b0);
	localparam trig_tab_t SIN_Q30 = build_tab(1'b1);

endpackage

/* hw/rtl/rema_if.sv */
// Valid/ready channel interfaces for pixel words and result words.
// Depends on rema_pkg for the field widths.
interface rema_pix_if;
	logic                         valid;
	logic                         ready;
	logic [rema_pkg::PIX_W-1:0]   pixel;
	logic                         frame_start;
	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface rema_res_if;
	logic                         valid;
	logic                         ready;
	logic [rema_pkg::MAG_W-1:0]   edge_magnitude;
	logic [rema_pkg::ANG_W-1:0]   edge_angle;
	logic [rema_pkg::COL_W-1:0]   column;
	logic                         last_of_run;
	modport source (output valid, output edge_magnitude, output edge_angle,
		output column, output last_of_run, input ready);
	modport sink (input valid, input edge_magnitude, input edge_angle,
		input column, input last_of_run, output ready);
endinterface

/* hw/rtl/rema_ctrl.sv */
// Controller state machine for the edge block.
// Sequences capture, window load, and up to two result jobs. Uses rema_pkg.
module rema_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              pix_valid,
	output logic              pix_ready,
	output logic              res_valid,
	input  logic              res_ready,
	input  rema_pkg::sts_t    sts,
	output rema_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_LOAD  = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_ITER  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;
	localparam logic [2:0] S_OUT   = 3'd5;

	logic [2:0] state_q;
	logic       job_q;
	logic       has1_q;

	assign pix_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && pix_valid;
		cmd.load    = (state_q == S_LOAD);
		cmd.start   = (state_q == S_START);
		cmd.job     = job_q;
		cmd.step    = (state_q == S_ITER);
		cmd.finish  = (state_q == S_FIN);
		cmd.last    = job_q || !has1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			job_q   <= 1'b0;
			has1_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pix_valid) state_q <= S_LOAD;
				end
				S_LOAD: begin
					has1_q <= sts.has1;
					job_q  <= !sts.has0;
					if (sts.has0 || sts.has1) state_q <= S_START;
					else state_q <= S_IDLE;
				end
				S_START: state_q <= S_ITER;
				S_ITER: begin
					if (sts.iter_done) state_q <= S_FIN;
				end
				S_FIN: state_q <= S_OUT;
				S_OUT: begin
					if (res_ready) begin
						if (!job_q && has1_q) begin
							job_q   <= 1'b1;
							state_q <= S_START;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* hw/rtl/rema_dp.sv */
// Datapath of the edge block: line buffer, window, pair selection,
// iterative square root and threshold-count arctangent. Uses rema_pkg.
module rema_dp #(
	parameter int MAX_ROW_WIDTH = rema_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rema_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic [rema_pkg::PIX_W-1:0]     pixel,
	input  logic                           frame_start,
	input  rema_pkg::cmd_t                 cmd,
	output rema_pkg::sts_t                 sts,
	output logic [rema_pkg::MAG_W-1:0]     edge_magnitude,
	output logic [rema_pkg::ANG_W-1:0]     edge_angle,
	output logic [rema_pkg::COL_W-1:0]     column,
	output logic                           last_of_run
);

	localparam int CW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int WW = (CW + 1 > rema_pkg::CFG_W) ? CW + 1 : rema_pkg::CFG_W;
	localparam int LW = rema_pkg::LEN_W;
	localparam int RB = rema_pkg::SQRT_BITS;
	localparam int KW = rema_pkg::K_W;
	localparam int TW = rema_pkg::TRIG_W;
	localparam int PW = rema_pkg::PIX_W;

	logic [rema_pkg::CFG_W-1:0] row_width_q;
	logic [PW-1:0]              row_mem [MAX_ROW_WIDTH];
	logic [CW-1:0]              colcnt_q;
	logic                       above_valid_q;
	logic [PW-1:0]              left_cur_q, left_above_q;

	logic [PW-1:0]              p_q, above_q;
	logic [CW-1:0]              col_q;
	logic                       av_q, lastcol_q;

	logic signed [8:0]          jx_q [2];
	logic signed [8:0]          jy_q [2];
	logic [LW-1:0]              jl_q [2];

	logic signed [8:0]          x_q, y_q;
	logic [LW-1:0]              len_q;
	logic [PW-1:0]              u_q, v_q;
	logic                       swap_q, sdiff_q;
	logic [RB-1:0]              r_q;
	logic [KW-1:0]              k_q;
	logic [KW-1:0]              cnt_q;
	logic                       job_q;

	logic [WW-1:0]              w_eff, col_ext, col_next;
	logic [CW-1:0]              col_eff;

	function automatic logic [LW-1:0] sqlen(logic signed [8:0] x, logic signed [8:0] y);
		logic [PW-1:0] ax, ay;
		logic [LW-1:0] ex, ey;
		ax = x[8] ? PW'(-x) : x[PW-1:0];
		ay = y[8] ? PW'(-y) : y[PW-1:0];
		ex = {{(LW-PW){1'b0}}, ax};
		ey = {{(LW-PW){1'b0}}, ay};
		return ex * ex + ey * ey;
	endfunction

	// Clamp the configured width and wrap an out-of-range counter to column 0.
	always_comb begin
		logic [WW-1:0] rw;
		rw = WW'(row_width_q);
		if (rw < WW'(2)) w_eff = WW'(2);
		else if (rw > WW'(MAX_ROW_WIDTH)) w_eff = WW'(MAX_ROW_WIDTH);
		else w_eff = rw;
		col_ext = frame_start ? '0 : WW'(colcnt_q);
		if (col_ext >= w_eff) col_ext = '0;
		col_eff  = col_ext[CW-1:0];
		col_next = col_ext + WW'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= rema_pkg::ROW_WIDTH_RESET;
		end else if (cfg_we) begin
			row_width_q <= cfg_wdata;
		end
	end

	// Read happens before write, so the old pixel of this column comes out.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			above_q          <= row_mem[col_eff];
			row_mem[col_eff] <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colcnt_q      <= '0;
			above_valid_q <= 1'b0;
			left_cur_q    <= '0;
			left_above_q  <= '0;
		end else begin
			if (cmd.capture) begin
				if (col_next >= w_eff) begin
					colcnt_q      <= '0;
					above_valid_q <= 1'b1;
				end else begin
					colcnt_q      <= col_next[CW-1:0];
					above_valid_q <= frame_start ? 1'b0 : above_valid_q;
				end
			end
			if (cmd.load) begin
				left_cur_q   <= p_q;
				left_above_q <= above_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			p_q       <= pixel;
			col_q     <= col_eff;
			av_q      <= frame_start ? 1'b0 : above_valid_q;
			lastcol_q <= (col_ext == w_eff - WW'(1));
		end
	end

	assign sts.has0 = av_q && (col_q != '0);
	assign sts.has1 = av_q && lastcol_q;

	// Pair P and pair Q for both jobs; Q wins only on a strictly longer length.
	always_ff @(posedge clk) begin
		logic signed [8:0] sa, sb, sc, sd;
		logic signed [8:0] px, py, qx, qy;
		logic [LW-1:0]     lp, lq;
		sa = $signed({1'b0, left_above_q});
		sb = $signed({1'b0, above_q});
		sc = $signed({1'b0, left_cur_q});
		sd = $signed({1'b0, p_q});
		if (cmd.load) begin
			px = sa - sd;
			py = sb - sc;
			qx = sd - sc;
			qy = sa - sc;
			lp = sqlen(px, py);
			lq = sqlen(qx, qy);
			jx_q[0] <= (lq > lp) ? qx : px;
			jy_q[0] <= (lq > lp) ? qy : py;
			jl_q[0] <= (lq > lp) ? lq : lp;
			px = sb;
			py = -sd;
			qx = -sd;
			qy = sb - sd;
			lp = sqlen(px, py);
			lq = sqlen(qx, qy);
			jx_q[1] <= (lq > lp) ? qx : px;
			jy_q[1] <= (lq > lp) ? qy : py;
			jl_q[1] <= (lq > lp) ? lq : lp;
		end
	end

	assign sts.iter_done = (k_q == KW'(rema_pkg::NTHRESH - 1));

	always_ff @(posedge clk) begin
		logic signed [8:0]  jx, jy;
		logic [PW-1:0]      ax, ay;
		logic [TW+PW-1:0]   lhs, rhs;
		logic [RB-1:0]      t;
		logic [2*RB-1:0]    tt;
		logic [2*RB+1:0]    rr;
		logic [RB:0]        rf;
		logic [rema_pkg::ANG_W-1:0] n;
		logic [31:0]        colw;
		if (cmd.start) begin
			jx = jx_q[cmd.job];
			jy = jy_q[cmd.job];
			ax = jx[8] ? PW'(-jx) : jx[PW-1:0];
			ay = jy[8] ? PW'(-jy) : jy[PW-1:0];
			x_q     <= jx;
			y_q     <= jy;
			len_q   <= jl_q[cmd.job];
			swap_q  <= (ay > ax);
			u_q     <= (ay > ax) ? ay : ax;
			v_q     <= (ay > ax) ? ax : ay;
			sdiff_q <= jx[8] != jy[8];
			r_q     <= '0;
			k_q     <= '0;
			cnt_q   <= '0;
			job_q   <= cmd.job;
		end
		if (cmd.step) begin
			lhs = {{TW{1'b0}}, v_q} * {{PW{1'b0}}, rema_pkg::COS_Q30[k_q]};
			rhs = {{TW{1'b0}}, u_q} * {{PW{1'b0}}, rema_pkg::SIN_Q30[k_q]};
			if (lhs > rhs) cnt_q <= cnt_q + KW'(1);
			// The root takes one result bit per step over the first steps.
			if (k_q < KW'(RB)) begin
				t  = r_q | (RB'(1) << (KW'(RB - 1) - k_q));
				tt = {{RB{1'b0}}, t} * {{RB{1'b0}}, t};
				if ({{(2*RB-LW){1'b0}}, len_q} >= tt) r_q <= t;
			end
			k_q <= k_q + KW'(1);
		end
		if (cmd.finish) begin
			rr = {{(RB+2){1'b0}}, r_q} * ({{(RB+2){1'b0}}, r_q} + (2*RB+2)'(1));
			rf = {1'b0, r_q};
			if ({{(2*RB+2-LW){1'b0}}, len_q} > rr) rf = rf + (RB+1)'(1);
			edge_magnitude <= (rf > (RB+1)'(255)) ? 8'd255 : rf[rema_pkg::MAG_W-1:0];
			if (x_q == '0) begin
				n = (y_q == '0) ? '0 : rema_pkg::ANGLE_RIGHT;
			end else if (y_q == '0) begin
				n = '0;
			end else begin
				n = swap_q ? rema_pkg::ANGLE_RIGHT - 7'(cnt_q) : 7'(cnt_q);
				if (sdiff_q) n = rema_pkg::ANGLE_RIGHT - n;
			end
			edge_angle  <= n;
			colw        = 32'(col_q) - (job_q ? 32'd0 : 32'd1);
			column      <= colw[rema_pkg::COL_W-1:0];
			last_of_run <= cmd.last;
		end
	end

endmodule

/* hw/rtl/roberts_edge_magnitude_angle.sv */
// Roberts edge magnitude and angle, one pixel word at a time.
// A pixel yields no, one or two result words, each passing through start, 45
// arctangent threshold steps that also carry the 10-step root, finish and
// output, held there by output stalls. Both words share one threshold-compare
// unit; no pixel is taken until the last word is out. Reset clears control state,
// column counter, left window and row_width (512); the line buffer is not cleared.
module roberts_edge_magnitude_angle #(
	parameter int MAX_ROW_WIDTH = rema_pkg::MAX_ROW_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	rema_pix_if.sink                   pix,
	rema_res_if.source                 res,
	input  logic                       cfg_we,
	input  logic [rema_pkg::CFG_W-1:0] cfg_wdata
);

	rema_pkg::cmd_t cmd;
	rema_pkg::sts_t sts;

	rema_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.res_valid (res.valid),
		.res_ready (res.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rema_dp #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.pixel          (pix.pixel),
		.frame_start    (pix.frame_start),
		.cmd            (cmd),
		.sts            (sts),
		.edge_magnitude (res.edge_magnitude),
		.edge_angle     (res.edge_angle),
		.column         (res.column),
		.last_of_run    (res.last_of_run)
	);

endmodule

/* tb/roberts_edge_magnitude_angle_test.sv */
// Self-checking testbench for roberts_edge_magnitude_angle: drives pixel words,
// predicts every result word from its own model of the line buffer and arctangent.
// Depends on rema_pkg, the rema_pix_if/rema_res_if interfaces and the block itself.
`timescale 1ns / 1ps

module roberts_edge_magnitude_angle_test;

	typedef struct {
		logic [rema_pkg::MAG_W-1:0] magnitude;
		logic [rema_pkg::ANG_W-1:0] angle;
		logic [rema_pkg::COL_W-1:0] column;
		logic                       last;
	} edge_word_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rema_pkg::CFG_W-1:0] cfg_wdata;

	rema_pix_if pix_ch ();
	rema_res_if res_ch ();

	roberts_edge_magnitude_angle u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Model state of the block.
	longint unsigned cos_tab [rema_pkg::NTHRESH];
	longint unsigned sin_tab [rema_pkg::NTHRESH];
	logic [rema_pkg::CFG_W-1:0] width_reg;
	logic [rema_pkg::PIX_W-1:0] line_buf [rema_pkg::MAX_ROW_WIDTH_DEF];
	logic [rema_pkg::PIX_W-1:0] left_cur;
	logic [rema_pkg::PIX_W-1:0] left_up;
	int unsigned      col_count;
	bit               up_valid;

	edge_word_t edge_queue [$];
	int         mismatches;
	int         items_sent;
	int         burst_left;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic longint unsigned q30_mul(longint unsigned a, longint unsigned b);
		return (a * b + 64'd536870912) >> 30;
	endfunction

	task automatic make_trig_tables();
		longint unsigned h, h2, h3, h4, s, c, s1, c1, pc, ps;
		h  = (64'h3243F6A8885A308D / 64'd360 + 64'd536870912) >> 30;
		h2 = q30_mul(h, h);
		h3 = q30_mul(h2, h);
		h4 = q30_mul(h2, h2);
		s  = h - (h3 + 3) / 6;
		c  = 64'd1073741824 - (h2 + 1) / 2 + (h4 + 12) / 24;
		s1 = 2 * q30_mul(s, c);
		c1 = 64'd1073741824 - 2 * q30_mul(s, s);
		cos_tab[0] = c;
		sin_tab[0] = s;
		for (int k = 1; k < rema_pkg::NTHRESH; k++) begin
			pc = cos_tab[k-1];
			ps = sin_tab[k-1];
			cos_tab[k] = q30_mul(pc, c1) - q30_mul(ps, s1);
			sin_tab[k] = q30_mul(ps, c1) + q30_mul(pc, s1);
		end
	endtask

	// Number of half-degree thresholds that atan(v/u) lies above.
	function automatic int unsigned thresholds_passed(longint unsigned u, longint unsigned v);
		int unsigned n;
		n = 0;
		for (int k = 0; k < rema_pkg::NTHRESH; k++)
			if (v * cos_tab[k] > u * sin_tab[k])
				n++;
		return n;
	endfunction

	function automatic int unsigned edge_degrees(int x, int y);
		longint unsigned ax, ay;
		int unsigned     n;
		if (x == 0)
			return (y == 0) ? 0 : int'(rema_pkg::ANGLE_RIGHT);
		if (y == 0)
			return 0;
		ax = 64'((x < 0) ? -x : x);
		ay = 64'((y < 0) ? -y : y);
		if (ay <= ax)
			n = thresholds_passed(ax, ay);
		else
			n = 90 - thresholds_passed(ay, ax);
		if ((x < 0) != (y < 0))
			n = 90 - n;
		return n;
	endfunction

	function automatic int unsigned rounded_sqrt(int unsigned s);
		int unsigned r, t;
		r = 0;
		for (int b = 512; b != 0; b = b >> 1) begin
			t = r | b;
			if (t * t <= s)
				r = t;
		end
		if (s > r * (r + 1))
			r++;
		return (r > 255) ? 255 : r;
	endfunction

	function automatic edge_word_t pick_gradient(int px, int py, int qx, int qy, int unsigned col);
		edge_word_t  w;
		int unsigned lp, lq;
		int          x, y;
		lp = px * px + py * py;
		lq = qx * qx + qy * qy;
		x = px;
		y = py;
		if (lq > lp) begin
			x  = qx;
			y  = qy;
			lp = lq;
		end
		w.magnitude = rema_pkg::MAG_W'(rounded_sqrt(lp));
		w.angle     = rema_pkg::ANG_W'(edge_degrees(x, y));
		w.column    = rema_pkg::COL_W'(col);
		w.last      = 1'b0;
		return w;
	endfunction

	// Advances the model by one accepted pixel and queues the words it causes.
	task automatic predict_edges(logic [rema_pkg::PIX_W-1:0] p, bit fs);
		int unsigned      w, col;
		logic [rema_pkg::PIX_W-1:0] up;
		edge_word_t       words [$];
		w = 32'(width_reg);
		if (w < 2)
			w = 2;
		if (w > rema_pkg::MAX_ROW_WIDTH_DEF)
			w = rema_pkg::MAX_ROW_WIDTH_DEF;
		col = col_count;
		if (fs) begin
			up_valid = 1'b0;
			col = 0;
		end
		if (col >= w)
			col = 0;
		up = line_buf[col];
		if (up_valid) begin
			if (col > 0)
				words.push_back(pick_gradient(int'(left_up) - int'(p), int'(up) - int'(left_cur),
					int'(p) - int'(left_cur), int'(left_up) - int'(left_cur), col - 1));
			if (col == w - 1)
				words.push_back(pick_gradient(int'(up), -int'(p), -int'(p),
					int'(up) - int'(p), col));
			if (words.size() > 0)
				words[words.size()-1].last = 1'b1;
			foreach (words[i])
				edge_queue.push_back(words[i]);
		end
		line_buf[col] = p;
		left_cur = p;
		left_up = up;
		col++;
		if (col >= w) begin
			col = 0;
			up_valid = 1'b1;
		end
		col_count = col;
	endtask

	// Sends one pixel word, with random gaps between bursts.
	task automatic send_pixel(logic [rema_pkg::PIX_W-1:0] p, bit fs);
		int gap;
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				pix_ch.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		pix_ch.valid = 1'b1;
		pix_ch.pixel = p;
		pix_ch.frame_start = fs;
		do
			@(posedge clk);
		while (!pix_ch.ready);
		predict_edges(p, fs);
		items_sent++;
	endtask

	// Lowers valid and waits until every predicted word has come out.
	task automatic drain_results();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (edge_queue.size() > 0)
			@(posedge clk);
	endtask

	task automatic write_row_width(logic [rema_pkg::CFG_W-1:0] value);
		drain_results();
		// A pixel with no result may still be in flight.
		repeat (8) @(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		width_reg = value;
	endtask

	function automatic logic [rema_pkg::PIX_W-1:0] random_pixel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return rema_pkg::PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic test_narrow_extremes();
		logic [rema_pkg::PIX_W-1:0] rows [7][2] = '{'{0, 255}, '{255, 0}, '{0, 0},
			'{255, 255}, '{255, 0}, '{0, 255}, '{0, 0}};
		write_row_width(10'd0);
		foreach (rows[r, c])
			send_pixel(rows[r][c], r == 0 && c == 0);
		write_row_width(10'd1);
		send_pixel(8'd17, 1'b1);
		send_pixel(8'd200, 1'b0);
		send_pixel(8'd90, 1'b0);
		send_pixel(8'd3, 1'b0);
	endtask

	// Lowering the width while the column counter is past it restarts the row at column 0.
	task automatic test_width_shrink_mid_row();
		write_row_width(10'd6);
		for (int i = 0; i < 10; i++)
			send_pixel(random_pixel(), i == 0);
		write_row_width(10'd3);
		for (int i = 0; i < 6; i++)
			send_pixel(random_pixel(), 1'b0);
		write_row_width(10'd1023);
		for (int i = 0; i < 4; i++)
			send_pixel(random_pixel(), 1'b0);
	endtask

	task automatic test_random_frames();
		int unsigned w, rows;
		while (items_sent < 550) begin
			case ($urandom_range(0, 9))
				0: w = $urandom_range(13, 40);
				1: w = ($urandom_range(0, 1) == 0) ? 0 : 1023;
				default: w = $urandom_range(2, 12);
			endcase
			write_row_width(rema_pkg::CFG_W'(w));
			if (w < 2)
				w = 2;
			if (w > rema_pkg::MAX_ROW_WIDTH_DEF)
				w = 4;
			rows = $urandom_range(2, 4);
			for (int r = 0; r < rows; r++)
				for (int c = 0; c < w; c++) begin
					if ($urandom_range(0, 29) == 0)
						drain_results();
					send_pixel(random_pixel(),
						(r == 0 && c == 0) || $urandom_range(0, 39) == 0);
				end
			// Zero row flushes the last image row.
			for (int c = 0; c < w; c++)
				send_pixel(8'd0, 1'b0);
		end
	endtask

	// Result receiver: stretches of full readiness, random stalls and long stalls.
	always @(negedge clk) begin : res_stall
		static int mode = 0;
		static int left = 0;
		if (left == 0) begin
			mode = $urandom_range(0, 2);
			left = $urandom_range(5, 80);
		end
		left--;
		case (mode)
			0: res_ch.ready = 1'b1;
			1: res_ch.ready = 1'($urandom_range(0, 1));
			default: res_ch.ready = ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		edge_word_t w;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (edge_queue.size() == 0) begin
				$display("%0t: unexpected word mag=%0d ang=%0d col=%0d last=%0d", $time,
					res_ch.edge_magnitude, res_ch.edge_angle, res_ch.column,
					res_ch.last_of_run);
				mismatches++;
			end else begin
				w = edge_queue.pop_front();
				if (res_ch.edge_magnitude !== w.magnitude || res_ch.edge_angle !== w.angle ||
					res_ch.column !== w.column || res_ch.last_of_run !== w.last) begin
					$display("%0t: expected mag=%0d ang=%0d col=%0d last=%0d, got mag=%0d ang=%0d col=%0d last=%0d",
						$time, w.magnitude, w.angle, w.column, w.last,
						res_ch.edge_magnitude, res_ch.edge_angle, res_ch.column,
						res_ch.last_of_run);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#2_000_000;
		$display("** roberts_edge_magnitude_angle: FAILED **");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.frame_start = 1'b0;
		res_ch.ready = 1'b0;
		mismatches = 0;
		items_sent = 0;
		burst_left = 0;
		width_reg = rema_pkg::ROW_WIDTH_RESET;
		left_cur = '0;
		left_up = '0;
		col_count = 0;
		up_valid = 1'b0;
		foreach (line_buf[i])
			line_buf[i] = '0;
		make_trig_tables();
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_narrow_extremes();
		test_width_shrink_mid_row();
		test_random_frames();

		drain_results();
		repeat (120) @(posedge clk);
		if (mismatches == 0 && edge_queue.size() == 0)
			$display("** roberts_edge_magnitude_angle: PASSED **");
		else
			$display("** roberts_edge_magnitude_angle: FAILED **");
		$finish;
	end

endmodule

/* roberts_edge_magnitude_angle.f */
hw/rtl/rema_pkg.sv
hw/rtl/rema_if.sv
hw/rtl/rema_ctrl.sv
hw/rtl/rema_dp.sv
hw/rtl/roberts_edge_magnitude_angle.sv
tb/roberts_edge_magnitude_angle_test.sv
